// ----- hw/rtl/gfb_pkg.sv -----
// ----------------------------------------------------------------------------
// gfb_pkg
// Shared constants and types of the gateway frame builder: frame bytes,
// field widths, byte positions of the frame sequencer and the job record.
// ----------------------------------------------------------------------------
package gfb_pkg;

    localparam int MAX_FRAME      = 1024;
    localparam int FRAME_OVERHEAD = 30;
    localparam int BODY_LIM       = MAX_FRAME - FRAME_OVERHEAD;

    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 10;
    localparam int FLEN_W    = 11;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 8;

    localparam logic [7:0] BYTE_PRE   = 8'hFB;
    localparam logic [7:0] BYTE_SUF   = 8'hFD;
    localparam logic [7:0] BYTE_START = 8'h7B;
    localparam logic [7:0] BYTE_VER   = 8'h03;

    // byte positions within the 30-byte sequence
    localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
    localparam logic [POS_W-1:0] POS_SUM_FIRST = 5'd3;
    localparam logic [POS_W-1:0] POS_SUM_LAST  = 5'd25;
    localparam logic [POS_W-1:0] POS_CHECK     = 5'd26;
    localparam logic [POS_W-1:0] POS_LAST      = 5'd29;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BODY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 8'd1;

    localparam logic [ADDR_W-1:0] SRC_ADDR_RESET = 48'h1;
    localparam logic [ADDR_W-1:0] DST_ADDR_RESET = 48'h1234;

    typedef enum logic [1:0]
    {
        JOB_HDR,
        JOB_BODY,
        JOB_STRAY
    } job_kind_t;

    typedef struct packed
    {
        job_kind_t          kind;
        logic [7:0]         msg_index;
        logic [7:0]         msg_code;
        logic [LEN_W-1:0]   len;
        logic [47:0]        timestamp;
        logic [7:0]         data_byte;
        logic               with_tail;
        logic [7:0]         tail_check;
        logic [FLEN_W-1:0]  flen;
    } gfb_job_t;

endpackage

// ----- hw/rtl/gfb_serializer.sv -----
// ----------------------------------------------------------------------------
// gfb_serializer
// Holds one job and walks it out one byte per cycle, when not stalled, into the
// output register: header, echoed body byte or drop marker, and the frame tail.
// ----------------------------------------------------------------------------
module gfb_serializer
    import gfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADDR_W-1:0]   src_addr,
    input  logic [ADDR_W-1:0]   dst_addr,
    input  logic                job_valid,
    output logic                job_ready,
    input  gfb_job_t            job,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // out_byte[7:0], frame_length[18:8]
    output logic                m_axis_tlast,
    output logic [1:0]          m_axis_tuser    // frame_end[0], status[1]
);

    gfb_job_t           job_reg;
    logic               job_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         hsum_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic [FLEN_W-1:0]  out_flen_reg;
    logic               out_last_reg;
    logic               out_fend_reg;
    logic               out_status_reg;

    logic [7:0]         seq_byte [0:31];
    logic [7:0]         cur_byte;
    logic [POS_W-1:0]   last_pos;
    logic               is_last;
    logic               emit;
    logic               job_load;
    logic               fend;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            seq_byte[i] = 8'h00;
        end
        seq_byte[0] = BYTE_PRE;
        seq_byte[1] = BYTE_PRE;
        seq_byte[2] = BYTE_START;
        seq_byte[3] = BYTE_VER;
        for (int i = 0; i < 6; i++)
        begin
            seq_byte[4 + i]  = src_addr[8*i +: 8];
            seq_byte[10 + i] = dst_addr[8*i +: 8];
            seq_byte[20 + i] = job_reg.timestamp[8*i +: 8];
        end
        seq_byte[16] = job_reg.msg_index;
        seq_byte[17] = job_reg.len[7:0];
        seq_byte[18] = {6'd0, job_reg.len[9:8]};
        seq_byte[19] = job_reg.msg_code;
        case (job_reg.kind)
            JOB_HDR:   seq_byte[26] = ~hsum_reg + 8'd1;
            JOB_BODY:  seq_byte[26] = job_reg.data_byte;
            default:   seq_byte[26] = 8'h00;
        endcase
        seq_byte[27] = job_reg.tail_check;
        seq_byte[28] = BYTE_SUF;
        seq_byte[29] = BYTE_SUF;
    end

    assign cur_byte  = seq_byte[pos_reg];
    assign last_pos  = job_reg.with_tail ? POS_LAST : POS_CHECK;
    assign is_last   = (pos_reg == last_pos);
    assign emit      = job_valid_reg && (!out_valid_reg || m_axis_tready);
    assign job_ready = !job_valid_reg || (emit && is_last);
    assign job_load  = job_valid && job_ready;
    assign fend      = job_reg.with_tail && (pos_reg == POS_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pos_reg       <= POS_FIRST;
            hsum_reg      <= 8'h00;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            pos_reg       <= (job.kind == JOB_HDR) ? POS_FIRST : POS_CHECK;
            hsum_reg      <= 8'h00;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                job_valid_reg <= 1'b0;
            end
            pos_reg <= pos_reg + 5'd1;
            if (pos_reg >= POS_SUM_FIRST && pos_reg <= POS_SUM_LAST)
            begin
                hsum_reg <= hsum_reg + cur_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= cur_byte;
            out_last_reg   <= is_last;
            out_fend_reg   <= fend;
            out_flen_reg   <= fend ? job_reg.flen : '0;
            out_status_reg <= (job_reg.kind == JOB_STRAY);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_flen_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_status_reg, out_fend_reg};

    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fend_reg) |-> out_last_reg)
        else $error("frame end without last flag");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (pos_reg <= last_pos))
        else $error("sequencer ran past last byte");

    a_job_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last && !job_valid) |=> !job_valid_reg)
        else $error("finished job not retired");

endmodule

// ----- hw/rtl/gateway_frame_builder_top.sv -----
// ----------------------------------------------------------------------------
// gateway_frame_builder_top
// Concentrator frame builder: start items open a frame and send its header,
// body items are echoed and summed, the tail closes the frame.
//
//   channel  dir  handshake                payload
//   s_axis   in   s_axis_tvalid/tready     tdata item fields, tuser cmd
//   m_axis   out  m_axis_tvalid/tready     tdata byte+length, tlast, tuser
//   cfg      in   cfg_valid/cfg_ready      cfg_index, cfg_data (48 bits)
//
// One output byte per cycle from the serializer's output register while
// m_axis_tready does not stall it. A body item sends one byte (four when it
// closes the frame), a start item 27 bytes (30 for an empty body), a stray
// body byte one. Reset clears frame state, loads the default addresses and
// empties the job and output registers. s_axis_tready is high while no job is held
// and, on the last byte of a job, when m_axis_tready is high or the output is idle.
// ----------------------------------------------------------------------------
module gateway_frame_builder_top
    import gfb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // msg_index[7:0], msg_code[15:8], body_len[25:16], timestamp[73:26],
    // data_byte[81:74]
    input  logic [87:0]             s_axis_tdata,
    input  logic                    s_axis_tuser,   // cmd[0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // out_byte[7:0], frame_length[18:8]
    output logic                    m_axis_tlast,   // run_last
    output logic [1:0]              m_axis_tuser,   // frame_end[0], status[1]
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_data
);

    logic [ADDR_W-1:0]  src_addr_reg;
    logic [ADDR_W-1:0]  dst_addr_reg;
    logic               in_frame_reg;
    logic [LEN_W-1:0]   bytes_left_reg;
    logic [7:0]         body_sum_reg;
    logic [LEN_W-1:0]   body_total_reg;

    logic               in_frame_next;
    logic [LEN_W-1:0]   bytes_left_next;
    logic [7:0]         body_sum_next;
    logic [LEN_W-1:0]   body_total_next;

    logic               s_fire;
    logic               job_ready;
    gfb_job_t           job;

    logic [7:0]         f_index;
    logic [7:0]         f_code;
    logic [LEN_W-1:0]   f_len;
    logic [47:0]        f_ts;
    logic [7:0]         f_data;
    logic [LEN_W-1:0]   len_sat;
    logic [7:0]         sum_new;
    logic [LEN_W-1:0]   left_new;

    assign f_index = s_axis_tdata[7:0];
    assign f_code  = s_axis_tdata[15:8];
    assign f_len   = s_axis_tdata[25:16];
    assign f_ts    = s_axis_tdata[73:26];
    assign f_data  = s_axis_tdata[81:74];

    assign s_axis_tready = job_ready;
    assign s_fire        = s_axis_tvalid && job_ready;
    assign cfg_ready     = 1'b1;

    assign len_sat  = (int'(f_len) > BODY_LIM) ? LEN_W'(BODY_LIM) : f_len;
    assign sum_new  = body_sum_reg + f_data;
    assign left_new = (bytes_left_reg != '0) ? bytes_left_reg - 10'd1 : '0;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        body_sum_next   = body_sum_reg;
        body_total_next = body_total_reg;

        job.kind       = JOB_STRAY;
        job.msg_index  = f_index;
        job.msg_code   = f_code;
        job.len        = len_sat;
        job.timestamp  = f_ts;
        job.data_byte  = f_data;
        job.with_tail  = 1'b0;
        job.tail_check = 8'h00;
        job.flen       = {1'b0, body_total_reg} + FLEN_W'(FRAME_OVERHEAD);

        if (s_axis_tuser == CMD_START)
        begin
            job.kind        = JOB_HDR;
            job.flen        = {1'b0, len_sat} + FLEN_W'(FRAME_OVERHEAD);
            body_total_next = len_sat;
            body_sum_next   = 8'h00;
            bytes_left_next = len_sat;
            if (len_sat == '0)
            begin
                job.with_tail = 1'b1;
                in_frame_next = 1'b0;
            end
            else
            begin
                in_frame_next = 1'b1;
            end
        end
        else if (in_frame_reg)
        begin
            job.kind        = JOB_BODY;
            bytes_left_next = left_new;
            if (left_new == '0)
            begin
                job.with_tail  = 1'b1;
                job.tail_check = ~sum_new + 8'd1;
                in_frame_next  = 1'b0;
                body_sum_next  = 8'h00;
            end
            else
            begin
                body_sum_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            body_sum_reg   <= 8'h00;
            body_total_reg <= '0;
        end
        else if (s_fire)
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            body_sum_reg   <= body_sum_next;
            body_total_reg <= body_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= SRC_ADDR_RESET;
            dst_addr_reg <= DST_ADDR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRC_ADDR: src_addr_reg <= cfg_data;
                CFG_DST_ADDR: dst_addr_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    gfb_serializer u_ser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_addr      (src_addr_reg),
        .dst_addr      (dst_addr_reg),
        .job_valid     (s_axis_tvalid),
        .job_ready     (job_ready),
        .job           (job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_open_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != '0))
        else $error("open frame with no bytes left");

    a_stray_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser == CMD_BODY && !in_frame_reg) |=>
        (!in_frame_reg && $stable(body_total_reg)))
        else $error("stray body byte changed frame state");

endmodule
